// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, skipped while reset is held.
`define HGRC_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define HGRC_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- hw/rtl/hgrc_pkg.sv -----
`default_nettype none

package hgrc_pkg;

    // map geometry
    localparam int MAP_SIDE_LOG2 = 6;
    localparam int MAP_SIDE      = 1 << MAP_SIDE_LOG2;
    localparam int MAP_CELLS     = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W        = 2 * MAP_SIDE_LOG2;
    localparam int IDX_W         = MAP_SIDE_LOG2;
    localparam int CNT_W         = MAP_SIDE_LOG2 + 1;
    localparam int ROW_W         = MAP_SIDE_LOG2 + 2;
    localparam int CELL_W        = 8;
    localparam logic [CELL_W-1:0] WALL_MIN = 8'h30;

    // fixed point
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = MAP_SIDE_LOG2 + FRAC_BITS;
    localparam int RECIP_W   = FRAC_BITS + 8;
    localparam int DIFF_W    = POS_W + 2;
    localparam int PROD_W    = DIFF_W + RECIP_W;
    localparam int XPOS_W    = 32;
    localparam int XCOL_W    = XPOS_W - 1 - FRAC_BITS;
    localparam int DIST_W    = 32;
    localparam logic [DIST_W-1:0] DIST_INF = '1;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = POS_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y = 2'd3;
    localparam logic [CNT_W-1:0] MAP_SIZE_RST = CNT_W'(MAP_SIDE);

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_CAST  = 1'b1;

    typedef logic signed [RECIP_W-1:0] t_recip;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;

endpackage

`default_nettype wire

// ----- hw/rtl/hgrc_in_if.sv -----
`default_nettype none

interface hgrc_in_if import hgrc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [IDX_W-1:0]     cell_row;
    logic [IDX_W-1:0]     cell_col;
    logic [CELL_W-1:0]    cell_value;
    logic                 goes_up;
    t_recip               inv_tan;
    t_recip               inv_sin;

    modport source (
        output valid, kind, cell_row, cell_col, cell_value, goes_up, inv_tan, inv_sin,
        input  ready
    );
    modport sink (
        input  valid, kind, cell_row, cell_col, cell_value, goes_up, inv_tan, inv_sin,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/hgrc_out_if.sv -----
`default_nettype none

interface hgrc_out_if import hgrc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [DIST_W-1:0]    distance;
    logic [POS_W-1:0]     hit_x;
    logic [POS_W-1:0]     hit_y;
    logic [IDX_W-1:0]     hit_row;

    modport source (
        output valid, hit, distance, hit_x, hit_y, hit_row,
        input  ready
    );
    modport sink (
        input  valid, hit, distance, hit_x, hit_y, hit_row,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/hgrc_ram.sv -----
`default_nettype none

module hgrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/hgrc_mul.sv -----
`default_nettype none

// Shared signed multiplier, one register after the product.
module hgrc_mul import hgrc_pkg::*; (
    input  wire logic  i_clk,
    input  wire t_diff i_a,
    input  wire t_recip i_b,
    output t_prod      o_prod
);

    always_ff @(posedge i_clk) begin
        o_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/horizontal_grid_ray_cast.sv -----
// Channel  Dir  Port     Payload
// -------  ---  -------  -----------------------------------------------------------
// request  in   i_req    kind, cell_row, cell_col, cell_value, goes_up, inv_tan, inv_sin
// result   out  o_res    hit, distance, hit_x, hit_y, hit_row
// config   in   i_cfg_*  write enable, register index, data (no read-back)
//
// A map write gives no result. A cast walks at most 63 rows: each row costs one
// map memory read and one test of its registered data. The shared multiplier forms
// the start point and, on a hit, the distance.
// Reset (synchronous, active low) clears the sequencer, the result valid and the player
// position and sets both map sizes to the map side. The map memory is not cleared.
// The request side is ready only while the sequencer is idle; a finished result
// waits in the output register, and only the next result stalls behind it.
`default_nettype none

module horizontal_grid_ray_cast import hgrc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    hgrc_in_if.sink                    i_req,
    hgrc_out_if.source                 o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_MUL_START = 3'd1;
    localparam logic [2:0] ST_ADD_X     = 3'd2;
    localparam logic [2:0] ST_CHECK     = 3'd3;
    localparam logic [2:0] ST_READ      = 3'd4;
    localparam logic [2:0] ST_MUL_DIST  = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    // line_y - player_y, both as fixed point; line is a grid line index
    function automatic t_diff line_diff(input logic [CNT_W-1:0] line,
                                        input logic [POS_W-1:0] py);
        logic [DIFF_W-1:0] a;
        logic [DIFF_W-1:0] b;
        a = {1'b0, line, {FRAC_BITS{1'b0}}};
        b = {2'b00, py};
        return t_diff'(a - b);
    endfunction

    // configuration registers
    logic [CNT_W-1:0] r_map_cols;
    logic [CNT_W-1:0] r_map_rows;
    logic [POS_W-1:0] r_player_x;
    logic [POS_W-1:0] r_player_y;

    // sequencer and walk registers
    logic [2:0]              r_state,  n_state;
    logic                    r_up;
    t_recip                  r_itan;
    t_recip                  r_isin;
    t_diff                   r_diff,   n_diff;
    logic signed [XPOS_W-1:0] r_ddx,   n_ddx;
    logic signed [ROW_W-1:0] r_dy,     n_dy;
    logic [CNT_W-1:0]        r_line,   n_line;
    logic                    r_found,  n_found;

    // result register
    logic                    r_out_valid, n_out_valid;
    logic                    r_o_hit;
    logic [DIST_W-1:0]       r_o_dist;
    logic [POS_W-1:0]        r_o_hit_x;
    logic [POS_W-1:0]        r_o_hit_y;
    logic [IDX_W-1:0]        r_o_hit_row;
    logic                    load_out;

    // datapath signals
    logic                    req_acc;
    logic                    cast_acc;
    logic [CNT_W-1:0]        cols_eff;
    logic [CNT_W-1:0]        rows_eff;
    logic [IDX_W-1:0]        start_row;
    logic [CNT_W-1:0]        start_line;
    logic signed [ROW_W-1:0] start_dy;
    logic                    out_of_map;
    logic [CELL_W-1:0]       cell_q;
    t_recip                  mul_b;
    t_prod                   prod;
    logic signed [XPOS_W-1:0] itan_ext;

    assign req_acc  = i_req.valid && i_req.ready;
    assign cast_acc = req_acc && (i_req.kind == KIND_CAST);
    assign i_req.ready = (r_state == ST_IDLE);

    // sizes above the map side act as the map side
    assign cols_eff = (r_map_cols > CNT_W'(MAP_SIDE)) ? CNT_W'(MAP_SIDE) : r_map_cols;
    assign rows_eff = (r_map_rows > CNT_W'(MAP_SIDE)) ? CNT_W'(MAP_SIDE) : r_map_rows;

    // first line: up rays cross the line above the player row, down rays the one below
    assign start_row  = r_player_y[POS_W-1:FRAC_BITS];
    assign start_line = i_req.goes_up ? ({1'b0, start_row} + CNT_W'(1)) : {1'b0, start_row};
    assign start_dy   = i_req.goes_up ? (ROW_W'(start_row) + ROW_W'(1))
                                      : (ROW_W'(start_row) - ROW_W'(1));

    // leave on negative x, column past the map, or row outside the map
    assign out_of_map = r_ddx[XPOS_W-1]
                     || (r_ddx[XPOS_W-2:FRAC_BITS] >= XCOL_W'(cols_eff))
                     || r_dy[ROW_W-1]
                     || (r_dy >= $signed({1'b0, rows_eff}));

    assign itan_ext = XPOS_W'(r_itan);

    // the multiplier takes inv_sin for the distance and inv_tan for the start x;
    // keep inv_sin through the finish state so the distance product holds while stalled
    assign mul_b = ((r_state == ST_MUL_DIST) || (r_state == ST_FINISH)) ? r_isin : r_itan;

    hgrc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (r_diff),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    hgrc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAP_CELLS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (req_acc && (i_req.kind == KIND_WRITE)),
        .i_waddr ({i_req.cell_row, i_req.cell_col}),
        .i_wdata (i_req.cell_value),
        .i_re    (r_state == ST_CHECK),
        .i_raddr ({r_dy[IDX_W-1:0], r_ddx[FRAC_BITS +: IDX_W]}),
        .o_rdata (cell_q)
    );

    // configuration writes; the user must issue them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_cols <= MAP_SIZE_RST;
            r_map_rows <= MAP_SIZE_RST;
            r_player_x <= '0;
            r_player_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAP_COLS: r_map_cols <= i_cfg_data[CNT_W-1:0];
                CFG_MAP_ROWS: r_map_rows <= i_cfg_data[CNT_W-1:0];
                CFG_PLAYER_X: r_player_x <= i_cfg_data[POS_W-1:0];
                CFG_PLAYER_Y: r_player_y <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_diff   = r_diff;
        n_ddx    = r_ddx;
        n_dy     = r_dy;
        n_line   = r_line;
        n_found  = r_found;
        load_out = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (cast_acc) begin
                    n_diff  = line_diff(start_line, r_player_y);
                    n_dy    = start_dy;
                    n_line  = start_line;
                    n_state = ST_MUL_START;
                end
            end
            ST_MUL_START: begin
                n_state = ST_ADD_X;
            end
            ST_ADD_X: begin
                // floor of the product shifted down, added to the player x
                n_ddx   = XPOS_W'(prod >>> FRAC_BITS) + XPOS_W'(r_player_x);
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (out_of_map) begin
                    n_found = 1'b0;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (cell_q >= WALL_MIN) begin
                    n_found = 1'b1;
                    n_diff  = line_diff(r_line, r_player_y);
                    n_state = ST_MUL_DIST;
                end else begin
                    // advance one row in the ray's direction
                    if (r_up) begin
                        n_ddx  = r_ddx + itan_ext;
                        n_dy   = r_dy + ROW_W'(1);
                        n_line = r_line + CNT_W'(1);
                    end else begin
                        n_ddx  = r_ddx - itan_ext;
                        n_dy   = r_dy - ROW_W'(1);
                        n_line = r_line - CNT_W'(1);
                    end
                    n_state = ST_CHECK;
                end
            end
            ST_MUL_DIST: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff  <= n_diff;
        r_ddx   <= n_ddx;
        r_dy    <= n_dy;
        r_line  <= n_line;
        r_found <= n_found;
        if (cast_acc) begin
            r_up   <= i_req.goes_up;
            r_itan <= i_req.inv_tan;
            r_isin <= i_req.inv_sin;
        end
        if (load_out) begin
            r_o_hit <= r_found;
            if (r_found) begin
                // negative product clamps to zero; a positive one fits the field
                r_o_dist    <= prod[PROD_W-1] ? '0 : prod[FRAC_BITS +: DIST_W];
                r_o_hit_x   <= r_ddx[POS_W-1:0];
                r_o_hit_y   <= {r_line[IDX_W-1:0], {FRAC_BITS{1'b0}}};
                r_o_hit_row <= r_dy[IDX_W-1:0];
            end else begin
                r_o_dist    <= DIST_INF;
                r_o_hit_x   <= '0;
                r_o_hit_y   <= '0;
                r_o_hit_row <= '0;
            end
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.hit      = r_o_hit;
    assign o_res.distance = r_o_dist;
    assign o_res.hit_x    = r_o_hit_x;
    assign o_res.hit_y    = r_o_hit_y;
    assign o_res.hit_row  = r_o_hit_row;

endmodule

`default_nettype wire

// ----- hw/rtl/hgrc_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module hgrc_checker import hgrc_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_in_kind,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic              i_hit,
    input wire logic [DIST_W-1:0] i_distance,
    input wire logic [POS_W-1:0]  i_hit_x,
    input wire logic [POS_W-1:0]  i_hit_y,
    input wire logic [IDX_W-1:0]  i_hit_row
);

    // reset drops any pending result
    `HGRC_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // a stalled result stays offered
    `HGRC_ASSERT(a_out_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")

    // a cast occupies the block for the following cycle at least
    `HGRC_ASSERT(a_cast_busy, i_clk, i_rst_n, i_in_valid && i_in_ready && (i_in_kind == KIND_CAST) |=> !i_in_ready, "ready right after a cast")

    // a miss carries the endless distance and zero coordinates
    `HGRC_ASSERT(a_miss_fields, i_clk, i_rst_n, i_out_valid && !i_hit |-> (i_distance == DIST_INF) && (i_hit_x == '0) && (i_hit_y == '0) && (i_hit_row == '0), "miss result fields")

endmodule

bind horizontal_grid_ray_cast hgrc_checker u_hgrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_kind   (i_req.kind),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_hit       (o_res.hit),
    .i_distance  (o_res.distance),
    .i_hit_x     (o_res.hit_x),
    .i_hit_y     (o_res.hit_y),
    .i_hit_row   (o_res.hit_row)
);

`default_nettype wire

// ----- test/horizontal_grid_ray_cast_test.sv -----
`default_nettype none

module horizontal_grid_ray_cast_test;
    import hgrc_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 12;
    // Longer than the longest cast, so this covers a map write still in flight.
    localparam int SETTLE_CYCLES   = 160;
    // Cast time plus both sides' longest pause, plus settle and config writes.
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int RANDOM_PHASES   = 16;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int MAX_REPORTS     = 40;

    // Pacing of both handshake sides within a phase.
    typedef enum int {
        PACE_STEADY,
        PACE_RANDOM,
        PACE_BURSTY
    } pace_e;

    // Two copies of the map: one that the stimulus planner fills ahead of
    // time, one that follows the transactions the block actually accepts.
    typedef enum int {
        VIEW_PLAN,
        VIEW_MODEL
    } map_view_e;

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   cell_row;
        logic [IDX_W-1:0]   cell_col;
        logic [CELL_W-1:0]  cell_value;
        logic               goes_up;
        t_recip             inv_tan;
        t_recip             inv_sin;
        logic [4:0]         pause;
    } ray_req_t;

    typedef struct packed {
        logic               hit;
        logic [DIST_W-1:0]  distance;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [IDX_W-1:0]   row;
    } cast_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Request payload as driven; held in variables so every input is known
    // from time zero.
    logic               req_valid = 1'b0;
    logic               req_kind  = KIND_WRITE;
    logic [IDX_W-1:0]   req_row   = '0;
    logic [IDX_W-1:0]   req_col   = '0;
    logic [CELL_W-1:0]  req_value = '0;
    logic               req_up    = 1'b0;
    t_recip             req_tan   = '0;
    t_recip             req_sin   = '0;
    logic               res_ready = 1'b0;

    hgrc_in_if  req_if ();
    hgrc_out_if res_if ();

    assign req_if.valid      = req_valid;
    assign req_if.kind       = req_kind;
    assign req_if.cell_row   = req_row;
    assign req_if.cell_col   = req_col;
    assign req_if.cell_value = req_value;
    assign req_if.goes_up    = req_up;
    assign req_if.inv_tan    = req_tan;
    assign req_if.inv_sin    = req_sin;
    assign res_if.ready      = res_ready;

    horizontal_grid_ray_cast dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Shadow of the configuration registers; only changed while the block is idle.
    logic [6:0]       cfg_cols = 7'd64;
    logic [6:0]       cfg_rows = 7'd64;
    logic [POS_W-1:0] cfg_px   = '0;
    logic [POS_W-1:0] cfg_py   = '0;

    logic [CELL_W-1:0] cell_copy [2][MAP_CELLS];
    bit                cell_set  [MAP_CELLS];

    ray_req_t     request_plan [$];
    cast_result_t cast_results_due [$];

    pace_e pace     = PACE_RANDOM;
    int    wall_pct = 20;
    int    error_count = 0;

    // Handshake bookkeeping: the monitor counts transactions, the drivers
    // compare against what they last saw.
    int       req_accepts = 0;
    int       res_accepts = 0;
    int       req_seen    = 0;
    int       res_seen    = 0;
    logic     req_loaded  = 1'b0;
    ray_req_t req_cur;
    logic [4:0] req_hold   = '0;
    logic [4:0] ready_hold = '0;
    int       idle_cycles = 0;

    function automatic logic [4:0] draw_pause();
        case (pace)
            PACE_STEADY: return '0;
            PACE_BURSTY: return ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 16)) : '0;
            default:     return 5'($urandom_range(0, 16));
        endcase
    endfunction

    // Walk horizontal grid lines from the player position. In the plan view,
    // stop at the first cell never written and hand back its address in hole.
    function automatic void trace_ray(input map_view_e view, input logic up,
                                      input t_recip step_x, input t_recip dist_scale,
                                      output cast_result_t res, output int hole);
        longint one, py, row, line_y, x, cols, rows, prod;
        int addr;
        one  = longint'(1) << FRAC_BITS;
        py   = longint'(cfg_py);
        cols = (cfg_cols > 7'(MAP_SIDE)) ? longint'(MAP_SIDE) : longint'(cfg_cols);
        rows = (cfg_rows > 7'(MAP_SIDE)) ? longint'(MAP_SIDE) : longint'(cfg_rows);
        res = '0;
        res.distance = DIST_INF;
        hole = -1;
        // Up rays start on the line above the player's row, down rays on the
        // line at the bottom of it, looking into the row below.
        row = py >>> FRAC_BITS;
        if (up) begin
            row = row + 1;
            line_y = row * one;
        end else begin
            line_y = row * one;
            row = row - 1;
        end
        x = longint'(cfg_px) + (((line_y - py) * longint'(step_x)) >>> FRAC_BITS);
        // Exclusive bounds on both axes; a negative x is off the map.
        while (x >= 0 && (x >>> FRAC_BITS) < cols && row >= 0 && row < rows) begin
            addr = int'(row) * MAP_SIDE + int'(x >>> FRAC_BITS);
            if (view == VIEW_PLAN && !cell_set[addr]) begin
                hole = addr;
                return;
            end
            if (cell_copy[view][addr] >= WALL_MIN) begin
                prod = (line_y - py) * longint'(dist_scale);
                res.hit = 1'b1;
                // Reciprocal of the wrong sign gives a negative distance: clamp.
                if (prod < 0)
                    res.distance = '0;
                else if ((prod >>> FRAC_BITS) > longint'(DIST_INF))
                    res.distance = DIST_INF;
                else
                    res.distance = DIST_W'(prod >>> FRAC_BITS);
                res.x   = POS_W'(x);
                res.y   = POS_W'(line_y);
                res.row = IDX_W'(row);
                return;
            end
            if (up) begin
                x = x + longint'(step_x);
                line_y = line_y + one;
                row = row + 1;
            end else begin
                x = x - longint'(step_x);
                line_y = line_y - one;
                row = row - 1;
            end
        end
    endfunction

    function automatic ray_req_t random_req();
        ray_req_t r;
        r.kind       = KIND_WRITE;
        r.cell_row   = IDX_W'($urandom);
        r.cell_col   = IDX_W'($urandom);
        r.cell_value = CELL_W'($urandom);
        r.goes_up    = 1'($urandom);
        r.inv_tan    = t_recip'($urandom);
        r.inv_sin    = t_recip'($urandom);
        r.pause      = draw_pause();
        return r;
    endfunction

    function automatic logic [CELL_W-1:0] pick_cell_value();
        if ($urandom_range(0, 99) < wall_pct)
            return CELL_W'($urandom_range(32'(WALL_MIN), 255));
        return CELL_W'($urandom_range(0, 32'(WALL_MIN) - 1));
    endfunction

    // Slopes lean small so rays cross many rows; distance scales lean moderate.
    function automatic t_recip pick_recip(input logic slope);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                if (slope)
                    return t_recip'($urandom_range(0, 1 << 18) - (1 << 17));
                return t_recip'($urandom_range(0, 1 << 21) - (1 << 20));
            end
            4, 5: return t_recip'($urandom_range(0, 1 << 13) - (1 << 12));
            6, 7: return t_recip'($urandom);
            8: begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return t_recip'(24'h7FFFFF);
                    default: return t_recip'(24'h800000);
                endcase
            end
            default: return t_recip'((int'($urandom_range(0, 8)) - 4) << FRAC_BITS);
        endcase
    endfunction

    function automatic void plan_write(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                       input logic [CELL_W-1:0] v);
        ray_req_t q;
        q = random_req();
        q.kind       = KIND_WRITE;
        q.cell_row   = r;
        q.cell_col   = c;
        q.cell_value = v;
        cell_copy[VIEW_PLAN][int'(r) * MAP_SIDE + int'(c)] = v;
        cell_set[int'(r) * MAP_SIDE + int'(c)] = 1'b1;
        request_plan.push_back(q);
    endfunction

    // Fill every cell the ray would look at before it, so no cast ever reads
    // a cell that was never written.
    function automatic void plan_cast(input logic up, input t_recip step_x,
                                      input t_recip dist_scale);
        ray_req_t     q;
        cast_result_t scratch;
        int           hole;
        trace_ray(VIEW_PLAN, up, step_x, dist_scale, scratch, hole);
        while (hole >= 0) begin
            plan_write(IDX_W'(hole / MAP_SIDE), IDX_W'(hole % MAP_SIDE), pick_cell_value());
            trace_ray(VIEW_PLAN, up, step_x, dist_scale, scratch, hole);
        end
        q = random_req();
        q.kind    = KIND_CAST;
        q.goes_up = up;
        q.inv_tan = step_x;
        q.inv_sin = dist_scale;
        request_plan.push_back(q);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (error_count < MAX_REPORTS)
            $display("mismatch %s: got %0h, expected %0h", what, got, want);
        error_count++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_MAP_COLS: cfg_cols = value[6:0];
            CFG_MAP_ROWS: cfg_rows = value[6:0];
            CFG_PLAYER_X: cfg_px   = value;
            default:      cfg_py   = value;
        endcase
    endtask

    task automatic load_settings(input logic [6:0] cols, input logic [6:0] rows,
                                 input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
        write_reg(CFG_MAP_COLS, CFG_DATA_W'(cols));
        write_reg(CFG_MAP_ROWS, CFG_DATA_W'(rows));
        write_reg(CFG_PLAYER_X, px);
        write_reg(CFG_PLAYER_Y, py);
    endtask

    // Hold off the sender until every cast has answered, then let a
    // trailing map write finish before anything else touches the block.
    task automatic drain();
        while (request_plan.size() != 0 || req_loaded || cast_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Request driver: advance to the next planned transaction once the current
    // one is taken, sit out its pause, then hold valid until accepted.
    always @(negedge clk) begin
        if (req_accepts != req_seen) begin
            req_seen   = req_accepts;
            req_loaded = 1'b0;
        end
        if (!req_loaded && rst_n && request_plan.size() != 0) begin
            req_cur    = request_plan.pop_front();
            req_loaded = 1'b1;
            req_hold   = req_cur.pause;
        end
        if (req_loaded && req_hold == 0) begin
            req_valid <= 1'b1;
            req_kind  <= req_cur.kind;
            req_row   <= req_cur.cell_row;
            req_col   <= req_cur.cell_col;
            req_value <= req_cur.cell_value;
            req_up    <= req_cur.goes_up;
            req_tan   <= req_cur.inv_tan;
            req_sin   <= req_cur.inv_sin;
        end else begin
            if (req_loaded)
                req_hold = req_hold - 1'b1;
            req_valid <= 1'b0;
        end
    end

    // Result sink: after each result, hold ready low for a pause drawn from the pacing.
    always @(negedge clk) begin
        if (res_accepts != res_seen) begin
            res_seen   = res_accepts;
            ready_hold = draw_pause();
        end
        if (ready_hold == 0) begin
            res_ready <= 1'b1;
        end else begin
            ready_hold = ready_hold - 1'b1;
            res_ready <= 1'b0;
        end
    end

    // Monitor: predict on every accepted request, check every accepted result
    // against the oldest prediction, and watch for a stalled block.
    always @(posedge clk) begin
        cast_result_t want;
        int           hole;
        logic         moved;
        if (rst_n) begin
            moved = 1'b0;
            if (req_if.valid && req_if.ready) begin
                req_accepts++;
                moved = 1'b1;
                if (req_if.kind == KIND_WRITE) begin
                    cell_copy[VIEW_MODEL][int'(req_if.cell_row) * MAP_SIDE
                                          + int'(req_if.cell_col)] = req_if.cell_value;
                end else begin
                    trace_ray(VIEW_MODEL, req_if.goes_up, req_if.inv_tan, req_if.inv_sin,
                              want, hole);
                    cast_results_due.push_back(want);
                end
            end
            if (res_if.valid && res_if.ready) begin
                res_accepts++;
                moved = 1'b1;
                if (cast_results_due.size() == 0) begin
                    report_mismatch("result with no cast pending", longint'(res_if.hit), 0);
                end else begin
                    want = cast_results_due.pop_front();
                    if (res_if.hit != want.hit)
                        report_mismatch("hit", longint'(res_if.hit), longint'(want.hit));
                    if (res_if.distance != want.distance)
                        report_mismatch("distance", longint'(res_if.distance),
                                        longint'(want.distance));
                    if (res_if.hit_x != want.x)
                        report_mismatch("hit_x", longint'(res_if.hit_x), longint'(want.x));
                    if (res_if.hit_y != want.y)
                        report_mismatch("hit_y", longint'(res_if.hit_y), longint'(want.y));
                    if (res_if.hit_row != want.row)
                        report_mismatch("hit_row", longint'(res_if.hit_row),
                                        longint'(want.row));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL horizontal_grid_ray_cast");
                $finish;
            end
        end
    end

    initial begin
        int               ph;
        int               span;
        logic [6:0]       cols;
        logic [6:0]       rows;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed: player at x 32.5, y 32.25 on a full 64 x 64 map.
        load_settings(7'd64, 7'd64, POS_W'(22'h208000), POS_W'(22'h204000));
        pace     = PACE_RANDOM;
        wall_pct = 20;
        plan_write(6'd0, 6'd0, 8'h00);
        plan_write(6'd63, 6'd63, 8'hFF);
        plan_write(6'd33, 6'd32, WALL_MIN);          // lowest wall value
        plan_write(6'd31, 6'd32, WALL_MIN - 8'd1);   // just below a wall
        plan_write(6'd30, 6'd32, 8'hFF);
        plan_write(6'd33, 6'd63, 8'h40);
        // Straight up: wall right above.
        plan_cast(1'b1, '0, t_recip'(24'h010000));
        // Straight down through a non-wall: distance clamps at zero.
        plan_cast(1'b0, '0, t_recip'(24'h010000));
        // Same ray with a negative scale gives a positive distance.
        plan_cast(1'b0, '0, t_recip'(24'hFF0000));
        // Slope extremes leave the map on either side.
        plan_cast(1'b1, t_recip'(24'h7FFFFF), t_recip'(24'h7FFFFF));
        plan_cast(1'b1, t_recip'(24'h800000), t_recip'(24'h800000));
        // Crossing lands exactly on x = 64.0: outside, the bound is exclusive.
        plan_cast(1'b1, t_recip'(24'h2A0000), t_recip'(24'h010000));
        // A hair to the left stays in the last column and hits there.
        plan_cast(1'b1, t_recip'(24'h29FFFE), t_recip'(24'h010000));
        // Negative x counts as off the map; x exactly 0 does not.
        plan_cast(1'b1, -t_recip'(24'h2C0000), t_recip'(24'h010000));
        plan_cast(1'b1, -t_recip'(24'h2B5555), t_recip'(24'h010000));
        drain();

        // Random phases: each picks a map size, a player position, a wall
        // density and a pacing; the extremes of each register come around.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 8)
                0:       cols = 7'd64;
                1:       cols = 7'($urandom_range(1, 64));
                2:       cols = 7'd1;
                3:       cols = 7'd0;
                4:       cols = 7'd127;
                5:       cols = 7'($urandom_range(65, 127));
                6:       cols = 7'($urandom_range(2, 63));
                default: cols = 7'd64;
            endcase
            case ((ph + 3) % 8)
                0:       rows = 7'd64;
                1:       rows = 7'($urandom_range(1, 64));
                2:       rows = 7'd1;
                3:       rows = 7'd0;
                4:       rows = 7'd127;
                5:       rows = 7'($urandom_range(65, 127));
                6:       rows = 7'($urandom_range(2, 63));
                default: rows = 7'd64;
            endcase
            // Keep the player inside the used area most of the time.
            span = (cols == 0 || cols > 7'd64) ? MAP_SIDE : int'(cols);
            px = POS_W'($urandom_range(0, (span << FRAC_BITS) - 1));
            span = (rows == 0 || rows > 7'd64) ? MAP_SIDE : int'(rows);
            py = POS_W'($urandom_range(0, (span << FRAC_BITS) - 1));
            if (ph == 5)  px = '0;
            if (ph == 9)  px = '1;
            if (ph == 6)  py = '0;
            if (ph == 10) py = '1;
            load_settings(cols, rows, px, py);
            pace     = pace_e'(ph % 3);
            wall_pct = $urandom_range(2, 45);
            if (ph == 7) wall_pct = 100;
            // Count the fill writes that casts pull in toward the phase total.
            while (request_plan.size() < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 20)
                    plan_write(IDX_W'($urandom), IDX_W'($urandom), CELL_W'($urandom));
                else
                    plan_cast(1'($urandom), pick_recip(1'b1), pick_recip(1'b0));
            end
            drain();
        end

        if (error_count == 0)
            $display("PASS horizontal_grid_ray_cast");
        else
            $display("FAIL horizontal_grid_ray_cast");
        $finish;
    end

endmodule

`default_nettype wire
